[rtl/swrs_pkg.sv]
package swrs_pkg;

    // Window and sample sizing
    localparam int WINDOW_MAX     = 64;
    localparam int SAMPLE_BITS    = 30;
    localparam int SAMPLE_FIELD_W = 30;
    localparam int RANK_W         = 7;
    localparam int CFG_W          = 7;

    // Stored sample width: the sample is taken in its low SAMPLE_BITS bits
    localparam int DATA_W  = (SAMPLE_BITS < SAMPLE_FIELD_W) ? SAMPLE_BITS : SAMPLE_FIELD_W;
    localparam int DIGIT_W = (DATA_W > 1) ? $clog2(DATA_W) : 1;
    localparam int FILL_W  = $clog2(WINDOW_MAX + 1);
    localparam int AGE_W   = $clog2(WINDOW_MAX);
    localparam int IDX_W   = AGE_W;
    localparam int LEN_W   = (FILL_W > CFG_W) ? FILL_W : CFG_W;
    localparam int CNT_W   = (FILL_W > RANK_W) ? FILL_W : RANK_W;

    // Register port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = '0;
    localparam logic [CFG_W-1:0]     WINDOW_LENGTH_RESET = CFG_W'(8);

    typedef struct packed {
        logic [SAMPLE_FIELD_W-1:0] sample;
        logic [RANK_W-1:0]         rank;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_FIELD_W-1:0] smallest;
        logic [SAMPLE_FIELD_W-1:0] ranked_value;
        logic [SAMPLE_FIELD_W-1:0] largest;
        logic                      window_full;
        logic                      rank_clamped;
    } out_item_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_DROP,
        CELL_CLEAR,
        CELL_COMPARE,
        CELL_INSERT,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [FILL_W-1:0] fill;
        logic              sample_bit;
    } cell_ctrl_t;

endpackage

[rtl/swrs_cells.sv]
// Sorted cell chain. Cell i holds the i-th smallest held sample and its age
// (0 = newest). Values rotate MSB first, one bit per cycle, for the serial
// compare against the incoming sample and for serial readout.
module swrs_cells (
    input  logic                                clk,
    input  logic                                rst_n,
    input  swrs_pkg::cell_ctrl_t                ctrl,
    input  logic [swrs_pkg::DATA_W-1:0]         new_value,
    output logic [swrs_pkg::WINDOW_MAX-1:0]     msb_bits
);

    logic [swrs_pkg::DATA_W-1:0]     cell_value [swrs_pkg::WINDOW_MAX];
    logic [swrs_pkg::AGE_W-1:0]      cell_age   [swrs_pkg::WINDOW_MAX];
    logic [swrs_pkg::WINDOW_MAX-1:0] live;
    logic [swrs_pkg::WINDOW_MAX-1:0] rem;
    logic [swrs_pkg::WINDOW_MAX-1:0] shift_dn;
    logic [swrs_pkg::WINDOW_MAX-1:0] up;
    logic [swrs_pkg::AGE_W-1:0]      last_age;

    assign last_age = swrs_pkg::AGE_W'(ctrl.fill - swrs_pkg::FILL_W'(1));

    for (genvar i = 0; i < swrs_pkg::WINDOW_MAX; i++) begin : g_cell
        logic [swrs_pkg::DATA_W-1:0] value_reg;
        logic [swrs_pkg::AGE_W-1:0]  age_reg;
        logic                        decided_reg;
        logic                        greater_reg;
        logic                        prev_up;
        logic [swrs_pkg::DATA_W-1:0] below_value;
        logic [swrs_pkg::AGE_W-1:0]  below_age;
        logic [swrs_pkg::DATA_W-1:0] above_value;
        logic [swrs_pkg::AGE_W-1:0]  above_age;
        logic                        take_new;
        logic                        my_bit;

        if (i == 0) begin : g_first
            assign prev_up     = 1'b0;
            assign below_value = value_reg;
            assign below_age   = age_reg;
        end
        else begin : g_rest
            assign prev_up     = up[i-1];
            assign below_value = cell_value[i-1];
            assign below_age   = cell_age[i-1];
        end

        if (i == swrs_pkg::WINDOW_MAX - 1) begin : g_last
            assign above_value = value_reg;
            assign above_age   = age_reg;
        end
        else begin : g_inner
            assign above_value = cell_value[i+1];
            assign above_age   = cell_age[i+1];
        end

        assign cell_value[i] = value_reg;
        assign cell_age[i]   = age_reg;
        assign my_bit        = value_reg[swrs_pkg::DATA_W-1];
        assign msb_bits[i]   = my_bit;

        assign live[i]     = ctrl.fill > swrs_pkg::FILL_W'(i);
        assign rem[i]      = live[i] && (age_reg == last_age);
        assign shift_dn[i] = |rem[i:0];
        assign up[i]       = live[i] && greater_reg;
        assign take_new    = (up[i] || (ctrl.fill == swrs_pkg::FILL_W'(i))) && !prev_up;

        // Sample storage: no reset, cells above the fill are never read
        always_ff @(posedge clk)
        begin
            unique case (ctrl.op)
                swrs_pkg::CELL_DROP:
                begin
                    // close the gap left by the oldest sample
                    if (shift_dn[i])
                    begin
                        value_reg <= above_value;
                        age_reg   <= above_age;
                    end
                end
                swrs_pkg::CELL_COMPARE,
                swrs_pkg::CELL_ROTATE:
                begin
                    value_reg <= {value_reg[swrs_pkg::DATA_W-2:0], my_bit};
                end
                swrs_pkg::CELL_INSERT:
                begin
                    if (prev_up)
                    begin
                        value_reg <= below_value;
                        age_reg   <= below_age + swrs_pkg::AGE_W'(1);
                    end
                    else if (take_new)
                    begin
                        value_reg <= new_value;
                        age_reg   <= '0;
                    end
                    else
                    begin
                        age_reg <= age_reg + swrs_pkg::AGE_W'(1);
                    end
                end
                swrs_pkg::CELL_HOLD,
                swrs_pkg::CELL_CLEAR:
                begin
                end
            endcase
        end

        // Serial magnitude compare, MSB first: first differing bit decides
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                decided_reg <= 1'b0;
                greater_reg <= 1'b0;
            end
            else if (ctrl.op == swrs_pkg::CELL_CLEAR)
            begin
                decided_reg <= 1'b0;
                greater_reg <= 1'b0;
            end
            else if (ctrl.op == swrs_pkg::CELL_COMPARE && !decided_reg &&
                     (my_bit != ctrl.sample_bit))
            begin
                decided_reg <= 1'b1;
                greater_reg <= my_bit;
            end
        end
    end

endmodule

[rtl/sliding_window_rank_select_top.sv]
// Sliding-window rank filter.
// Input channel item_valid / item_stall / item carries one transaction per
// sample: the sample value and the rank to report (1 = minimum, 0 acts as 1).
// Output channel result_valid / result_stall / result returns exactly one
// transaction per input: window minimum, rank-th smallest, maximum, a flag
// for a full window and a flag for a rank clamped to the fill.
// The register window_length (byte address 0 on the APB port, reset 8) sets
// the window; write it only while the block is idle.
// Timing: samples move bit-serially, one bit per cycle, through the sorted
// cell chain. Each transaction runs a drop step that removes the D oldest
// samples (normally 1 once the window is full, 0 while filling, more right
// after the window shrinks), then a clear step, the compare pass, the insert
// step, the readout pass and a final step. A new sample is taken only once
// the block is back in idle.
// Reset empties the window; the stores need no clearing pass.
// A result waiting under result_stall does not block the next input: the
// block accepts it and works on it, and holds in its last step until the
// output register frees up.
module sliding_window_rank_select_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // sample channel
    input  logic                                item_valid,
    output logic                                item_stall,
    input  swrs_pkg::in_item_t                  item,
    // result channel
    output logic                                result_valid,
    input  logic                                result_stall,
    output swrs_pkg::out_item_t                 result,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [swrs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [swrs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [swrs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_COMPARE,
        ST_INSERT,
        ST_COLLECT,
        ST_DONE
    } state_t;

    state_t                              state_reg, state_next;
    logic [swrs_pkg::FILL_W-1:0]         fill_reg, fill_next;
    logic [swrs_pkg::CFG_W-1:0]          wl_reg, wl_next;
    logic [swrs_pkg::DATA_W-1:0]         sample_reg, sample_next;
    logic [swrs_pkg::RANK_W-1:0]         rank_reg, rank_next;
    logic [swrs_pkg::DIGIT_W-1:0]        digit_reg, digit_next;
    logic [swrs_pkg::DATA_W-1:0]         acc_min_reg, acc_min_next;
    logic [swrs_pkg::DATA_W-1:0]         acc_rank_reg, acc_rank_next;
    logic [swrs_pkg::DATA_W-1:0]         acc_max_reg, acc_max_next;
    swrs_pkg::out_item_t                 result_reg, result_next;
    logic                                result_valid_reg, result_valid_next;

    swrs_pkg::cell_ctrl_t                cell_ctrl;
    logic [swrs_pkg::WINDOW_MAX-1:0]     msb_bits;

    logic [swrs_pkg::LEN_W-1:0]          wl_ext;
    logic [swrs_pkg::FILL_W-1:0]         w_eff;
    logic [swrs_pkg::RANK_W-1:0]         rank_one;
    logic                                clamped;
    logic [swrs_pkg::IDX_W-1:0]          rank_idx;
    logic [swrs_pkg::IDX_W-1:0]          max_idx;
    logic [swrs_pkg::REG_IDX_W-1:0]      reg_idx;
    logic                                cfg_write;
    logic                                last_digit;

    swrs_cells u_cells (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (cell_ctrl),
        .new_value (sample_reg),
        .msb_bits  (msb_bits)
    );

    // Effective window: zero acts as one, saturate at the cell count
    always_comb
    begin
        wl_ext = swrs_pkg::LEN_W'(wl_reg);
        if (wl_reg == '0)
            w_eff = swrs_pkg::FILL_W'(1);
        else if (wl_ext > swrs_pkg::LEN_W'(swrs_pkg::WINDOW_MAX))
            w_eff = swrs_pkg::FILL_W'(swrs_pkg::WINDOW_MAX);
        else
            w_eff = swrs_pkg::FILL_W'(wl_ext);
    end

    // Rank select against the post-insert fill
    assign rank_one = (rank_reg == '0) ? swrs_pkg::RANK_W'(1) : rank_reg;
    assign clamped  = swrs_pkg::CNT_W'(rank_one) > swrs_pkg::CNT_W'(fill_reg);
    assign max_idx  = swrs_pkg::IDX_W'(fill_reg - swrs_pkg::FILL_W'(1));
    assign rank_idx = clamped ? max_idx
                              : swrs_pkg::IDX_W'(rank_one - swrs_pkg::RANK_W'(1));

    // Register port: word addressed, byte offset ignored
    assign reg_idx   = paddr[swrs_pkg::APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (reg_idx == swrs_pkg::REG_WINDOW_LENGTH)
                     ? swrs_pkg::APB_DATA_W'(wl_reg) : '0;

    assign last_digit   = digit_reg == swrs_pkg::DIGIT_W'(swrs_pkg::DATA_W - 1);
    assign item_stall   = state_reg != ST_IDLE;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next        = state_reg;
        fill_next         = fill_reg;
        wl_next           = wl_reg;
        sample_next       = sample_reg;
        rank_next         = rank_reg;
        digit_next        = digit_reg;
        acc_min_next      = acc_min_reg;
        acc_rank_next     = acc_rank_reg;
        acc_max_next      = acc_max_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;

        cell_ctrl.op         = swrs_pkg::CELL_HOLD;
        cell_ctrl.fill       = fill_reg;
        cell_ctrl.sample_bit = sample_reg[swrs_pkg::DATA_W-1];

        // drop the result once the receiver takes it
        if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;

        if (cfg_write && reg_idx == swrs_pkg::REG_WINDOW_LENGTH)
            wl_next = pwdata[swrs_pkg::CFG_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    sample_next = swrs_pkg::DATA_W'(item.sample);
                    rank_next   = item.rank;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                // drop oldest samples one per cycle until there is room
                if (fill_reg != '0 && fill_reg >= w_eff)
                begin
                    cell_ctrl.op = swrs_pkg::CELL_DROP;
                    fill_next    = fill_reg - swrs_pkg::FILL_W'(1);
                end
                else
                begin
                    cell_ctrl.op = swrs_pkg::CELL_CLEAR;
                    digit_next   = '0;
                    state_next   = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                // advance sample and cells together, MSB first
                cell_ctrl.op = swrs_pkg::CELL_COMPARE;
                sample_next  = {sample_reg[swrs_pkg::DATA_W-2:0],
                                sample_reg[swrs_pkg::DATA_W-1]};
                digit_next   = digit_reg + swrs_pkg::DIGIT_W'(1);
                if (last_digit)
                    state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                cell_ctrl.op = swrs_pkg::CELL_INSERT;
                fill_next    = fill_reg + swrs_pkg::FILL_W'(1);
                digit_next   = '0;
                state_next   = ST_COLLECT;
            end
            ST_COLLECT:
            begin
                // tap min, ranked and max cells one bit per cycle
                cell_ctrl.op  = swrs_pkg::CELL_ROTATE;
                acc_min_next  = {acc_min_reg[swrs_pkg::DATA_W-2:0], msb_bits[0]};
                acc_rank_next = {acc_rank_reg[swrs_pkg::DATA_W-2:0], msb_bits[rank_idx]};
                acc_max_next  = {acc_max_reg[swrs_pkg::DATA_W-2:0], msb_bits[max_idx]};
                digit_next    = digit_reg + swrs_pkg::DIGIT_W'(1);
                if (last_digit)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.smallest     = swrs_pkg::SAMPLE_FIELD_W'(acc_min_reg);
                    result_next.ranked_value = swrs_pkg::SAMPLE_FIELD_W'(acc_rank_reg);
                    result_next.largest      = swrs_pkg::SAMPLE_FIELD_W'(acc_max_reg);
                    result_next.window_full  = fill_reg == w_eff;
                    result_next.rank_clamped = clamped;
                    result_valid_next        = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            fill_reg         <= '0;
            wl_reg           <= swrs_pkg::WINDOW_LENGTH_RESET;
            digit_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            fill_reg         <= fill_next;
            wl_reg           <= wl_next;
            digit_reg        <= digit_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        rank_reg     <= rank_next;
        acc_min_reg  <= acc_min_next;
        acc_rank_reg <= acc_rank_next;
        acc_max_reg  <= acc_max_next;
        result_reg   <= result_next;
    end

    // Insert adds exactly one sample to the window
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INSERT |=>
            fill_reg == swrs_pkg::FILL_W'($past(fill_reg) + swrs_pkg::FILL_W'(1)))
    else $error("fill did not advance by one on insert");

    // A new result appears only out of the final step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg) == ST_DONE)
    else $error("result raised outside the final step");

    // An accepted transaction starts the drop step
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> state_reg == ST_PREP)
    else $error("accepted transaction did not start processing");

    // The readout never runs on an empty window
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_COLLECT |-> fill_reg != '0)
    else $error("readout from an empty window");

endmodule

[sim/rank_filter_check.sv]
module rank_filter_check
    import swrs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_stall,
    input  in_item_t              item,
    input  logic                  result_valid,
    input  logic                  result_stall,
    input  out_item_t             result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  pready,
    output int                    pending,
    output int                    fail_count
);

    // Window contents kept twice: ascending by value and oldest first
    logic [SAMPLE_FIELD_W-1:0] held_by_value[$];
    logic [SAMPLE_FIELD_W-1:0] held_by_arrival[$];
    logic [CFG_W-1:0]          window_length;
    out_item_t                 stats_due[$];
    out_item_t                 want;
    int                        errors = 0;
    int                        results_seen = 0;

    // Slide the window by one sample and return the statistics that follow
    function automatic out_item_t advance_window(input in_item_t it);
        logic [SAMPLE_FIELD_W-1:0] s;
        logic [SAMPLE_FIELD_W-1:0] gone;
        int                        span;
        int                        slot;
        int                        pick;
        out_item_t                 r;
        s = SAMPLE_FIELD_W'(it.sample[DATA_W-1:0]);
        span = (window_length == 0) ? 1 : int'(window_length);
        if (span > WINDOW_MAX)
            span = WINDOW_MAX;
        // drop oldest samples until one more fits, shrink included
        while (held_by_arrival.size() > 0 && held_by_arrival.size() >= span)
        begin
            gone = held_by_arrival.pop_front();
            slot = 0;
            while (slot < held_by_value.size() - 1 && held_by_value[slot] != gone)
                slot++;
            held_by_value.delete(slot);
        end
        slot = held_by_value.size();
        while (slot > 0 && held_by_value[slot-1] > s)
            slot--;
        held_by_value.insert(slot, s);
        held_by_arrival.insert(held_by_arrival.size(), s);
        pick = (it.rank == 0) ? 1 : int'(it.rank);
        r.rank_clamped = (pick > held_by_value.size());
        if (r.rank_clamped)
            pick = held_by_value.size();
        r.smallest     = held_by_value[0];
        r.ranked_value = held_by_value[pick-1];
        r.largest      = held_by_value[held_by_value.size()-1];
        r.window_full  = (held_by_value.size() == span);
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("result %0d: %s", results_seen, what);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_by_value.delete();
            held_by_arrival.delete();
            stats_due.delete();
            window_length = WINDOW_LENGTH_RESET;
            pending    <= 0;
            fail_count <= errors;
        end
        else
        begin
            if (psel && penable && pready && paddr[APB_ADDR_W-1:2] == REG_WINDOW_LENGTH)
            begin
                if (pwrite)
                    window_length = pwdata[CFG_W-1:0];
                else if (prdata !== APB_DATA_W'(window_length))
                    flag_mismatch($sformatf("window_length reads 0x%0h, holds 0x%0h",
                                            prdata, window_length));
            end
            // retire before predicting: no result belongs to a sample of this edge
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (stats_due.size() == 0)
                    flag_mismatch("result with no sample outstanding");
                else
                begin
                    want = stats_due.pop_front();
                    if (result.smallest !== want.smallest)
                        flag_mismatch($sformatf("smallest 0x%0h, expected 0x%0h",
                                                result.smallest, want.smallest));
                    if (result.ranked_value !== want.ranked_value)
                        flag_mismatch($sformatf("ranked_value 0x%0h, expected 0x%0h",
                                                result.ranked_value, want.ranked_value));
                    if (result.largest !== want.largest)
                        flag_mismatch($sformatf("largest 0x%0h, expected 0x%0h",
                                                result.largest, want.largest));
                    if (result.window_full !== want.window_full)
                        flag_mismatch($sformatf("window_full %b, expected %b",
                                                result.window_full, want.window_full));
                    if (result.rank_clamped !== want.rank_clamped)
                        flag_mismatch($sformatf("rank_clamped %b, expected %b",
                                                result.rank_clamped, want.rank_clamped));
                end
            end
            if (item_valid && !item_stall)
                stats_due.insert(stats_due.size(), advance_window(item));
            pending    <= stats_due.size();
            fail_count <= errors;
        end
    end

endmodule

[sim/tb.sv]
module tb;
    import swrs_pkg::*;

    // Longest quiet stretch: a full shrink drop pass plus the worst feed gap
    // and drain stall, taken many times over
    localparam int WATCHDOG_LIMIT = 4000;
    // Quiet time after the last result
    localparam int DRAIN_CYCLES   = 200;
    localparam int RANDOM_ITEMS   = 1880;
    // Register index with nothing behind it
    localparam logic [REG_IDX_W-1:0]      REG_UNMAPPED = REG_IDX_W'(1);
    localparam logic [SAMPLE_FIELD_W-1:0] SAMPLE_TOP   = '1;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_stall;
    in_item_t              item;
    logic                  result_valid;
    logic                  result_stall;
    out_item_t             result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    pending;
    int                    fail_count;
    int                    idle_cycles = 0;

    // Stretches of back-to-back traffic on either side
    bit                    steady_feed  = 1'b0;
    bit                    steady_drain = 1'b0;
    // Window length last written, raw register value
    logic [CFG_W-1:0]      cur_len = WINDOW_LENGTH_RESET;

    always #2 clk = ~clk;

    sliding_window_rank_select_top i_dut (.*);

    rank_filter_check i_check (.*);

    // Hold one transaction on the sample channel until it is taken.
    // The idle gap in front of it is drawn per transaction.
    task automatic send_item(input in_item_t it);
        int gap;
        if ($urandom_range(0, 63) == 0)
            steady_feed = !steady_feed;
        gap = steady_feed ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (item_stall);
    endtask

    task automatic feed(input logic [SAMPLE_FIELD_W-1:0] s, input logic [RANK_W-1:0] r);
        in_item_t it;
        it.sample = s;
        it.rank   = r;
        send_item(it);
    endtask

    // Drop valid and wait until every outstanding result has come back.
    // pending is a registered copy of the channel state, so look from the next edge on.
    task automatic settle();
        item_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // APB access: setup cycle, access cycle, then idle before the
    // next access; pready is always high
    task automatic reg_access(input logic [REG_IDX_W-1:0] idx, input logic wr,
                              input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Write the window length with junk in the unused upper bits, then read back
    task automatic set_window(input logic [CFG_W-1:0] len);
        logic [APB_DATA_W-1:0] word;
        word = ($urandom() & ~APB_DATA_W'({CFG_W{1'b1}})) | APB_DATA_W'(len);
        reg_access(REG_WINDOW_LENGTH, 1'b1, word);
        reg_access(REG_WINDOW_LENGTH, 1'b0, '0);
        cur_len = len;
    endtask

    // Mix extremes, tight ranges that force duplicates, and full-width noise
    function automatic logic [SAMPLE_FIELD_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return SAMPLE_TOP;
            2, 3:    return SAMPLE_FIELD_W'($urandom_range(0, 15));
            4:       return SAMPLE_TOP - SAMPLE_FIELD_W'($urandom_range(0, 15));
            default: return SAMPLE_FIELD_W'($urandom());
        endcase
    endfunction

    // Ranks: zero, above any fill, anywhere up to the maximum, one, exactly the window, and inside the window
    function automatic logic [RANK_W-1:0] pick_rank();
        int span;
        span = (cur_len == 0) ? 1 : int'(cur_len);
        if (span > WINDOW_MAX)
            span = WINDOW_MAX;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return RANK_W'($urandom_range(WINDOW_MAX + 1, 127));
            2:       return RANK_W'($urandom_range(1, WINDOW_MAX));
            3:       return RANK_W'(1);
            4:       return RANK_W'(span);
            default: return RANK_W'($urandom_range(1, span));
        endcase
    endfunction

    // Window lengths: zero, one, the maximum, saturating values, and the middle
    function automatic logic [CFG_W-1:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_W'(1);
            2:       return CFG_W'(WINDOW_MAX);
            3:       return CFG_W'($urandom_range(WINDOW_MAX + 1, 127));
            4:       return CFG_W'(2);
            default: return CFG_W'($urandom_range(2, WINDOW_MAX - 1));
        endcase
    endfunction

    // Result side: per transaction, either take it at once or raise stall
    // ahead of it and keep it up for a drawn number of cycles once valid shows
    initial
    begin
        int hold;
        result_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                steady_drain = !steady_drain;
            hold = steady_drain ? 0 : $urandom_range(0, 11);
            if (hold != 0)
            begin
                result_stall <= 1'b1;
                do @(posedge clk); while (!result_valid);
                repeat (hold - 1) @(posedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!(result_valid && !result_stall));
        end
    end

    // Watchdog: count edges at which neither channel moves a transaction
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL sliding_window_rank_select_top");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int done;
        int burst;
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset length of 8: fill with extremes and duplicates, clamp the
        // rank, use rank zero, then roll the full window over
        feed('0, 1);
        feed(SAMPLE_TOP, 1);
        feed(SAMPLE_TOP, 2);
        feed('0, 0);
        feed(5, 3);
        feed(5, 64);
        feed(30'h2000_0000, 127);
        feed(30'h2AAA_AAAA, 5);
        feed(30'h1555_5555, 8);
        feed(7, 4);

        // Shrink 8 -> 1: the next sample drops all older ones at once
        settle();
        set_window(1);
        feed(9, 0);
        feed(3, 2);
        feed(SAMPLE_TOP, 1);

        // Zero length behaves as one
        settle();
        set_window(0);
        feed(4, 1);
        feed(2, 127);

        // Above the maximum saturates, then the maximum itself
        settle();
        set_window(127);
        feed(SAMPLE_TOP, 2);
        feed(0, 3);
        settle();
        set_window(WINDOW_MAX);
        feed(11, 4);
        feed(6, 64);

        // Write to an unmapped index must leave the window length alone
        settle();
        reg_access(REG_UNMAPPED, 1'b1, 32'h0000_0003);
        reg_access(REG_WINDOW_LENGTH, 1'b0, '0);
        feed(1, 1);

        // Random bursts, most under a freshly written window length
        done = 0;
        while (done < RANDOM_ITEMS)
        begin
            settle();
            if ($urandom_range(0, 3) != 0)
                set_window(pick_length());
            burst = $urandom_range(8, 120);
            repeat (burst)
            begin
                feed(pick_sample(), pick_rank());
                done++;
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS sliding_window_rank_select_top");
        else
            $display("FAIL sliding_window_rank_select_top");
        $finish;
    end

endmodule
